// ----- rtl/spt_pkg.sv -----
// shared types and constants for the park transform and pwm block
`default_nettype none
package spt_pkg;
  localparam int DataWidth = 16;
  localparam int DutyWidth = 14;
  localparam int FracBits = 15;
  localparam int QuotWidth = DataWidth + 12;
  localparam int DivSteps = QuotWidth;
  localparam int DutyScale = 2000;
  localparam int DutyBase = 8500;
  localparam int QueueDepth = 4;
  localparam int QueueAw = 2;
  localparam int CfgIdxWidth = 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PWM_LIMIT  = 8'd0,
    REG_PWM_PERIOD = 8'd1
  } cfg_reg_e;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef struct packed {
    data_t i_alpha;
    data_t i_beta;
    data_t cos_theta;
    data_t sin_theta;
    data_t v_d;
    data_t v_q;
    data_t bus_voltage;
  } in_item_t;

  typedef struct packed {
    data_t i_d;
    data_t i_q;
    data_t v_alpha;
    data_t v_beta;
    logic [DutyWidth-1:0] duty_a_pos;
    logic [DutyWidth-1:0] duty_a_neg;
    logic [DutyWidth-1:0] duty_b_pos;
    logic [DutyWidth-1:0] duty_b_neg;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    data_t i_d;
    data_t i_q;
    data_t v_alpha;
    data_t v_beta;
    data_t bus;
    logic bus_ok;
  } mid_item_t;

  typedef struct packed {
    logic [15:0] pwm_limit;
    logic [15:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic [CfgIdxWidth-1:0] idx;
    logic [31:0] data;
  } cfg_item_t;

  // saturate a floor-shifted sum of two products
  function automatic data_t sat_shift(input logic signed [2*DataWidth:0] s);
    logic signed [2*DataWidth-FracBits:0] h;
    logic signed [2*DataWidth-FracBits:0] hi;
    logic signed [2*DataWidth-FracBits:0] lo;
    h = s[2*DataWidth:FracBits];
    hi = (2*DataWidth-FracBits+1)'(2**(DataWidth-1) - 1);
    lo = -hi - 1;
    if (h > hi) return data_t'(hi);
    if (h < lo) return data_t'(lo);
    return h[DataWidth-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/spt_if.sv -----
// valid/ready stream interfaces
`default_nettype none
interface spt_in_if;
  logic valid;
  logic ready;
  spt_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface spt_out_if;
  logic valid;
  logic ready;
  spt_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface spt_cfg_if;
  logic valid;
  logic ready;
  spt_pkg::cfg_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/spt_front.sv -----
// front end: park and inverse park transforms, two stage pipeline
`default_nettype none
module spt_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spt_in_if.sink in_if,
  output spt_pkg::mid_item_t mid_o,
  output logic mid_valid_o,
  input  wire logic mid_ready_i
);
  import spt_pkg::*;
  localparam int PW = 2*DataWidth;

  logic signed [PW-1:0] p_q [8];
  logic signed [PW-1:0] p_d [8];
  data_t bus_q;
  logic v1_q, v2_q;
  mid_item_t m_q;
  logic adv;

  assign adv = !v2_q || mid_ready_i;
  assign in_if.ready = adv || !v1_q;

  // products
  always_comb begin
    p_d[0] = in_if.data.i_alpha * in_if.data.cos_theta;
    p_d[1] = in_if.data.i_beta * in_if.data.sin_theta;
    p_d[2] = in_if.data.i_beta * in_if.data.cos_theta;
    p_d[3] = in_if.data.i_alpha * in_if.data.sin_theta;
    p_d[4] = in_if.data.v_d * in_if.data.cos_theta;
    p_d[5] = in_if.data.v_q * in_if.data.sin_theta;
    p_d[6] = in_if.data.v_q * in_if.data.cos_theta;
    p_d[7] = in_if.data.v_d * in_if.data.sin_theta;
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready) begin
      for (int k = 0; k < 8; k++) p_q[k] <= p_d[k];
      bus_q <= in_if.data.bus_voltage;
    end
    if (adv) begin
      m_q.i_d <= sat_shift((PW+1)'(p_q[0]) + (PW+1)'(p_q[1]));
      m_q.i_q <= sat_shift((PW+1)'(p_q[2]) - (PW+1)'(p_q[3]));
      m_q.v_alpha <= sat_shift((PW+1)'(p_q[4]) - (PW+1)'(p_q[5]));
      m_q.v_beta <= sat_shift((PW+1)'(p_q[6]) + (PW+1)'(p_q[7]));
      m_q.bus <= bus_q;
      m_q.bus_ok <= bus_q > 0;
    end
  end

  // valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_if.ready) v1_q <= in_if.valid;
      if (adv) v2_q <= v1_q;
    end
  end

  assign mid_o = m_q;
  assign mid_valid_o = v2_q;
endmodule
`default_nettype wire

// ----- rtl/spt_queue.sv -----
// small fifo between front and back
`default_nettype none
module spt_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  spt_pkg::mid_item_t wdata_i,
  input  wire logic wvalid_i,
  output logic wready_o,
  output spt_pkg::mid_item_t rdata_o,
  output logic rvalid_o,
  input  wire logic rready_i
);
  import spt_pkg::*;
  mid_item_t mem_q [QueueDepth];
  logic [QueueAw-1:0] wp_q, rp_q;
  logic [QueueAw:0] cnt_q;
  logic wr, rd;

  assign wready_o = cnt_q != (QueueAw+1)'(QueueDepth);
  assign rvalid_o = cnt_q != '0;
  assign wr = wvalid_i && wready_o;
  assign rd = rvalid_o && rready_i;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QueueAw+1)'(wr) - (QueueAw+1)'(rd);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/spt_back.sv -----
// back end: pipelined restoring dividers and duty leg generation
`default_nettype none
module spt_back (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  spt_pkg::cfg_t cfg_i,
  input  spt_pkg::mid_item_t mid_i,
  input  wire logic mid_valid_i,
  output logic mid_ready_o,
  spt_out_if.source out_if
);
  import spt_pkg::*;
  localparam int NS = DivSteps;
  localparam int QW = QuotWidth;
  localparam int DW = DataWidth;

  typedef struct packed {
    data_t i_d;
    data_t i_q;
    data_t v_alpha;
    data_t v_beta;
    logic bus_ok;
    logic [DW-1:0] den;
    logic [1:0] neg;
    logic [QW-1:0] ra;
    logic [QW-1:0] qa;
    logic [QW-1:0] rb;
    logic [QW-1:0] qb;
  } div_t;

  div_t st_q [NS+1];
  logic vl_q [NS+1];
  logic adv;
  out_item_t o_q;
  logic ov_q;
  logic [DutyWidth-1:0] limit;

  assign adv = !ov_q || out_if.ready;
  assign mid_ready_o = adv;

  // limit select
  always_comb begin
    if (cfg_i.pwm_limit != 16'd0 && cfg_i.pwm_limit < cfg_i.pwm_period)
      limit = cfg_i.pwm_limit >= 16'd2000 ? DutyWidth'(DutyScale)
                                          : cfg_i.pwm_limit[DutyWidth-1:0];
    else
      limit = cfg_i.pwm_period >= 16'd2000 ? DutyWidth'(DutyScale)
                                           : cfg_i.pwm_period[DutyWidth-1:0];
  end

  function automatic logic [QW-1:0] mag2000(input data_t v);
    logic [QW-1:0] a;
    a = v[DW-1] ? QW'(-$signed({v[DW-1], v})) : QW'(v);
    return QW'(a * QW'(DutyScale));
  endfunction

  function automatic void dstep(input logic [QW-1:0] r, input logic [QW-1:0] q,
                                input logic [DW-1:0] d, output logic [QW-1:0] ro,
                                output logic [QW-1:0] qo);
    logic [DW:0] t;
    logic [DW:0] s;
    t = {r[DW-1:0], q[QW-1]};
    s = t - {1'b0, d};
    qo = {q[QW-2:0], !s[DW]};
    ro = s[DW] ? QW'(t) : QW'(s);
  endfunction

  function automatic void legs(input logic [QW-1:0] q, input logic n,
                               input logic [DutyWidth-1:0] lim,
                               output logic [DutyWidth-1:0] p,
                               output logic [DutyWidth-1:0] m);
    logic [DutyWidth-1:0] mg;
    mg = q > QW'(lim) ? lim : q[DutyWidth-1:0];
    if (!n) begin
      p = DutyWidth'(DutyBase) - mg;
      m = DutyWidth'(DutyBase);
    end else begin
      p = DutyWidth'(DutyBase);
      m = DutyWidth'(DutyBase) - mg;
    end
  endfunction

  // divider stages, one quotient bit each
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0].i_d <= mid_i.i_d;
      st_q[0].i_q <= mid_i.i_q;
      st_q[0].v_alpha <= mid_i.v_alpha;
      st_q[0].v_beta <= mid_i.v_beta;
      st_q[0].bus_ok <= mid_i.bus_ok;
      st_q[0].den <= mid_i.bus;
      st_q[0].neg <= {mid_i.v_beta[DW-1], mid_i.v_alpha[DW-1]};
      st_q[0].ra <= '0;
      st_q[0].rb <= '0;
      st_q[0].qa <= mag2000(mid_i.v_alpha);
      st_q[0].qb <= mag2000(mid_i.v_beta);
      for (int k = 0; k < NS; k++) begin
        logic [QW-1:0] r1, q1, r2, q2;
        div_t nx;
        dstep(st_q[k].ra, st_q[k].qa, st_q[k].den, r1, q1);
        dstep(st_q[k].rb, st_q[k].qb, st_q[k].den, r2, q2);
        nx = st_q[k];
        nx.ra = r1;
        nx.qa = q1;
        nx.rb = r2;
        nx.qb = q2;
        st_q[k+1] <= nx;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [DutyWidth-1:0] ap, an, bp, bn;
      legs(st_q[NS].qa, st_q[NS].neg[0], limit, ap, an);
      legs(st_q[NS].qb, st_q[NS].neg[1], limit, bp, bn);
      o_q.i_d <= st_q[NS].i_d;
      o_q.i_q <= st_q[NS].i_q;
      o_q.v_alpha <= st_q[NS].v_alpha;
      o_q.v_beta <= st_q[NS].v_beta;
      o_q.duty_a_pos <= st_q[NS].bus_ok ? ap : '0;
      o_q.duty_a_neg <= st_q[NS].bus_ok ? an : '0;
      o_q.duty_b_pos <= st_q[NS].bus_ok ? bp : '0;
      o_q.duty_b_neg <= st_q[NS].bus_ok ? bn : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) vl_q[k] <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      vl_q[0] <= mid_valid_i;
      for (int k = 0; k < NS; k++) vl_q[k+1] <= vl_q[k];
      ov_q <= vl_q[NS];
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.data = o_q;
endmodule
`default_nettype wire

// ----- rtl/stepper_park_transform_and_pwm.sv -----
// top level: park transforms and stepper pwm duty generation
// pipeline: two front stages, the queue, a divider load stage plus 28 steps, and an output register
// throughput: one transaction per cycle while the output is ready, set by the one-bit-per-stage divider pipeline
// the queue between front and back absorbs stalls so each side runs on its own
// reset: asynchronous active low; pipelines empty, pwm_limit 0, pwm_period 8500
`default_nettype none
module stepper_park_transform_and_pwm (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spt_in_if.sink in_if,
  spt_out_if.source out_if,
  spt_cfg_if.sink cfg_if
);
  import spt_pkg::*;
  cfg_t cfg_q;
  mid_item_t f2q, q2b;
  logic f2q_v, f2q_r, q2b_v, q2b_r;

  assign cfg_if.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_limit <= 16'd0;
      cfg_q.pwm_period <= 16'd8500;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.idx)
        REG_PWM_LIMIT:  cfg_q.pwm_limit <= cfg_if.data.data[15:0];
        REG_PWM_PERIOD: cfg_q.pwm_period <= cfg_if.data.data[15:0];
        default: ;
      endcase
    end
  end

  spt_front u_front (
    .clk_i, .rst_ni, .in_if,
    .mid_o(f2q), .mid_valid_o(f2q_v), .mid_ready_i(f2q_r)
  );

  spt_queue u_queue (
    .clk_i, .rst_ni,
    .wdata_i(f2q), .wvalid_i(f2q_v), .wready_o(f2q_r),
    .rdata_o(q2b), .rvalid_o(q2b_v), .rready_i(q2b_r)
  );

  spt_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .mid_i(q2b), .mid_valid_i(q2b_v), .mid_ready_o(q2b_r), .out_if
  );
endmodule
`default_nettype wire

// ----- test/stepper_park_transform_and_pwm_tb.sv -----
// self-checking testbench for the park transform and stepper pwm block
`timescale 1ns / 100ps
module stepper_park_transform_and_pwm_tb;
  import spt_pkg::*;

  localparam int DrainCycles = 48;
  localparam int WatchdogLimit = 6000;
  localparam int HoldCycles = 400;

  logic clk_i;
  logic rst_ni;

  spt_in_if in_if();
  spt_out_if out_if();
  spt_cfg_if cfg_if();

  stepper_park_transform_and_pwm uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  in_item_t pending_q[$];
  out_item_t expected_q[$];
  logic [15:0] cur_limit;
  logic [15:0] cur_period;
  int errors;
  int in_count;
  int out_count;
  int stall_cycles;
  int hold_left;
  bit hold_done;
  bit finishing;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // saturate a floor-shifted sum of products to the data range
  function automatic data_t rotate_sat(input longint p1, input longint p2);
    longint s;
    s = (p1 + p2) >>> FracBits;
    if (s > 32767) return data_t'(32767);
    if (s < -32768) return data_t'(-32768);
    return data_t'(s);
  endfunction

  // per-phase duty to leg compare values
  function automatic void phase_legs(input longint v, input longint bus, input longint lim,
                                     output logic [DutyWidth-1:0] pos,
                                     output logic [DutyWidth-1:0] neg);
    longint duty;
    duty = (v * DutyScale) / bus;
    if (duty > DutyScale) duty = DutyScale;
    if (duty < -DutyScale) duty = -DutyScale;
    if (duty > lim) duty = lim;
    if (duty < -lim) duty = -lim;
    if (duty >= 0) begin
      pos = DutyWidth'(DutyBase - duty);
      neg = DutyWidth'(DutyBase);
    end else begin
      pos = DutyWidth'(DutyBase);
      neg = DutyWidth'(DutyBase + duty);
    end
  endfunction

  // expected transforms and duties for one input transaction
  function automatic out_item_t transform_and_duty(input in_item_t x);
    out_item_t r;
    longint ia, ib, c, s, vd, vq, bus, lim;
    ia = x.i_alpha;
    ib = x.i_beta;
    c = x.cos_theta;
    s = x.sin_theta;
    vd = x.v_d;
    vq = x.v_q;
    bus = x.bus_voltage;
    r.i_d = rotate_sat(ia * c, ib * s);
    r.i_q = rotate_sat(ib * c, -(ia * s));
    r.v_alpha = rotate_sat(vd * c, -(vq * s));
    r.v_beta = rotate_sat(vq * c, vd * s);
    if (bus <= 0) begin
      r.duty_a_pos = '0;
      r.duty_a_neg = '0;
      r.duty_b_pos = '0;
      r.duty_b_neg = '0;
    end else begin
      if (cur_limit > 0 && cur_limit < cur_period) lim = cur_limit;
      else lim = cur_period;
      phase_legs(longint'(r.v_alpha), bus, lim, r.duty_a_pos, r.duty_a_neg);
      phase_legs(longint'(r.v_beta), bus, lim, r.duty_b_pos, r.duty_b_neg);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on result %0d field %s: got %0d expected %0d",
             out_count, field, got, want);
    errors++;
  endtask

  // random transaction, mostly with a positive bus, in some cases scaled near the voltages
  function automatic in_item_t random_item();
    in_item_t x;
    int sel;
    x.i_alpha = data_t'($urandom);
    x.i_beta = data_t'($urandom);
    x.cos_theta = data_t'($urandom);
    x.sin_theta = data_t'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      x.v_d = data_t'($urandom_range(0, 8000)) - data_t'(4000);
      x.v_q = data_t'($urandom_range(0, 8000)) - data_t'(4000);
      x.bus_voltage = data_t'($urandom_range(1, 12000));
    end else if (sel < 8) begin
      x.v_d = data_t'($urandom);
      x.v_q = data_t'($urandom);
      x.bus_voltage = data_t'($urandom_range(1, 32767));
    end else begin
      x.v_d = data_t'($urandom);
      x.v_q = data_t'($urandom);
      x.bus_voltage = data_t'($urandom);
    end
    return x;
  endfunction

  function automatic in_item_t mk(input int ia, ib, c, s, vd, vq, bus);
    in_item_t x;
    x.i_alpha = data_t'(ia);
    x.i_beta = data_t'(ib);
    x.cos_theta = data_t'(c);
    x.sin_theta = data_t'(s);
    x.v_d = data_t'(vd);
    x.v_q = data_t'(vq);
    x.bus_voltage = data_t'(bus);
    return x;
  endfunction

  // register write while the block is idle
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data.idx <= idx;
    cfg_if.data.data <= {16'($urandom), value};
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_PWM_LIMIT) cur_limit = value;
    else cur_limit = cur_limit;
    if (idx == REG_PWM_PERIOD) cur_period = value;
    cfg_if.valid <= 1'b0;
  endtask

  // sender pause until every expected transaction has come back
  task automatic drain();
    wait (pending_q.size() == 0 && !in_if.valid);
    wait (expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n);
    repeat (n) pending_q.push_back(random_item());
    drain();
  endtask

  // stimulus sequence
  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    cur_limit = 16'd0;
    cur_period = 16'd8500;
    finishing = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // field extremes, overflow, bus off, negative and saturated duty
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    pending_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 1));
    pending_q.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767, 100));
    pending_q.push_back(mk(1000, -1000, 32767, 0, 1200, -1200, 2400));
    pending_q.push_back(mk(-5, 7, 0, 32767, -600, 300, 2400));
    pending_q.push_back(mk(100, 200, 23170, 23170, 5000, 5000, -1));
    pending_q.push_back(mk(100, 200, 23170, -23170, 5000, -5000, -32768));
    pending_q.push_back(mk(-1, -1, 1, 1, -1, -1, 32767));
    pending_q.push_back(mk(12345, -23456, -32768, 0, -32768, 32767, 1));
    pending_q.push_back(mk(32767, -32768, 16384, -16384, 20000, -20000, 30000));
    run_phase(140);

    write_reg(REG_PWM_LIMIT, 16'd1000);
    run_phase(150);
    write_reg(REG_PWM_PERIOD, 16'd0);
    write_reg(REG_PWM_LIMIT, 16'd0);
    run_phase(120);
    write_reg(REG_PWM_LIMIT, 16'hFFFF);
    write_reg(REG_PWM_PERIOD, 16'hFFFF);
    run_phase(160);
    write_reg(REG_PWM_LIMIT, 16'd3000);
    write_reg(REG_PWM_PERIOD, 16'd2500);
    run_phase(120);
    write_reg(REG_PWM_LIMIT, 16'd1);
    write_reg(REG_PWM_PERIOD, 16'd8500);
    run_phase(100);
    write_reg(REG_PWM_LIMIT, 16'd500);
    write_reg(REG_PWM_PERIOD, 16'hFFFF);
    run_phase(150);

    finishing = 1'b1;
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // input driver; no idling in a stretch of the run
  always @(posedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_if.ready)) begin
      if (pending_q.size() != 0 &&
          ((in_count > 450 && in_count < 620) || $urandom_range(0, 99) >= 15)) begin
        in_if.valid <= 1'b1;
        in_if.data <= pending_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_count >= 300) begin
      out_if.ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_if.ready <= (out_count > 700 && out_count < 850) || $urandom_range(0, 99) >= 15;
    end
  end

  // monitor: predict on input transactions, compare on output transactions
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(transform_and_duty(in_if.data));
        in_count <= in_count + 1;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_q.size() == 0) begin
          $display("unexpected result transaction %0d", out_count);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.i_d !== want.i_d) report_mismatch("i_d", got.i_d, want.i_d);
          if (got.i_q !== want.i_q) report_mismatch("i_q", got.i_q, want.i_q);
          if (got.v_alpha !== want.v_alpha)
            report_mismatch("v_alpha", got.v_alpha, want.v_alpha);
          if (got.v_beta !== want.v_beta)
            report_mismatch("v_beta", got.v_beta, want.v_beta);
          if (got.duty_a_pos !== want.duty_a_pos)
            report_mismatch("duty_a_pos", got.duty_a_pos, want.duty_a_pos);
          if (got.duty_a_neg !== want.duty_a_neg)
            report_mismatch("duty_a_neg", got.duty_a_neg, want.duty_a_neg);
          if (got.duty_b_pos !== want.duty_b_pos)
            report_mismatch("duty_b_pos", got.duty_b_pos, want.duty_b_pos);
          if (got.duty_b_neg !== want.duty_b_neg)
            report_mismatch("duty_b_neg", got.duty_b_neg, want.duty_b_neg);
        end
        out_count <= out_count + 1;
      end
    end
  end

  initial begin
    errors = 0;
    in_count = 0;
    out_count = 0;
    stall_cycles = 0;
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || finishing || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end
endmodule

// ----- stepper_park_transform_and_pwm.f -----
rtl/spt_pkg.sv
rtl/spt_if.sv
rtl/spt_front.sv
rtl/spt_queue.sv
rtl/spt_back.sv
rtl/stepper_park_transform_and_pwm.sv
test/stepper_park_transform_and_pwm_tb.sv
